// File: rtl/core/asp_pkg.sv
package asp_pkg;

    localparam int unsigned MAX_EDGES_DEF    = 256;
    localparam int unsigned QUEUE_DEPTH_DEF  = 512;
    localparam int unsigned VERTEX_CODES_DEF = 256;

    localparam logic [23:0] DIST_INF = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef logic signed [25:0] prio_t;

    typedef struct packed {
        prio_t       prio;
        logic [7:0]  vert;
    } heap_entry_t;

    typedef struct packed {
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [15:0] len;
    } edge_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PUSH_START,
        ST_PUSH_CMP,
        ST_PUSH_FIN,
        ST_POP_START,
        ST_POP_TOP,
        ST_POP_LAST,
        ST_POP_C,
        ST_POP_RC1,
        ST_POP_RC2,
        ST_POP_CMP,
        ST_CHECK,
        ST_EXP_D,
        ST_EXP_K,
        ST_EXP_E,
        ST_EXP_N,
        ST_FINISH,
        ST_TR_W,
        ST_TR_R,
        ST_RD_W,
        ST_EMIT
    } state_t;

    // Priority is the distance plus sixteen times (goal - vertex).
    function automatic prio_t prio_of(logic [23:0] dist_val, logic [7:0] goal, logic [7:0] v);
        logic signed [9:0] diff;
        diff = $signed({2'b00, goal}) - $signed({2'b00, v});
        return $signed({2'b00, dist_val}) + $signed({{12{diff[9]}}, diff, 4'b0000});
    endfunction

    function automatic logic outranks(heap_entry_t a, heap_entry_t b);
        logic r;
        if (a.prio != b.prio)
        begin
            r = (a.prio < b.prio);
        end
        else
        begin
            r = (a.vert > b.vert);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/asp_if.sv
interface asp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  edge_source;
    logic [7:0]  edge_target;
    logic [15:0] edge_length;
    logic [7:0]  start_vertex;
    logic [7:0]  goal_vertex;

    modport source (output valid, cmd, edge_source, edge_target, edge_length,
                    start_vertex, goal_vertex, input ready);
    modport sink   (input valid, cmd, edge_source, edge_target, edge_length,
                    start_vertex, goal_vertex, output ready);
endinterface

interface asp_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [23:0] goal_distance;
    logic [7:0]  path_vertex;
    logic        path_last;
    logic        overflow;

    modport source (output valid, found, goal_distance, path_vertex, path_last, overflow,
                    input ready);
    modport sink   (input valid, found, goal_distance, path_vertex, path_last, overflow,
                    output ready);
endinterface

// File: rtl/core/astar_shortest_path.sv
// Clear and edge load are handled in the idle state and can follow back to back.
// A path read goes through ST_RD_W if a vertex is left to read, then waits in ST_EMIT.
// A search pops the open queue, scans the edges of each popped vertex and pushes improved
// neighbours, then traces the path back through the predecessors; no beat is taken meanwhile.
// Reset is asynchronous and active low; it clears control state and the edge count, while the
// memories keep their contents and a search clears its own valid and closed bits when taken.
module astar_shortest_path #(
    parameter int unsigned MAX_EDGES    = asp_pkg::MAX_EDGES_DEF,
    parameter int unsigned QUEUE_DEPTH  = asp_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned VERTEX_CODES = asp_pkg::VERTEX_CODES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    asp_req_if.sink   req,
    asp_rsp_if.source rsp
);
    import asp_pkg::*;

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int VW  = $clog2(VERTEX_CODES);
    localparam int PCW = $clog2(VERTEX_CODES + 1);

    logic [7:0] mod_tbl [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        assign mod_tbl[g] = 8'(g % VERTEX_CODES);
    end

    edge_t       edge_mem [MAX_EDGES];
    heap_entry_t heap_mem [QUEUE_DEPTH];
    logic [23:0] dist_mem [VERTEX_CODES];
    logic [7:0]  pred_mem [VERTEX_CODES];
    logic [7:0]  pbuf_mem [VERTEX_CODES];

    logic             edge_we;
    logic [EW-1:0]    edge_waddr, edge_raddr;
    edge_t            edge_wdata, edge_rd_reg;
    logic             heap_we;
    logic [QW-1:0]    heap_waddr, heap_raddr;
    heap_entry_t      heap_wdata, heap_rd_reg;
    logic             dist_we;
    logic [VW-1:0]    dist_waddr, dist_raddr;
    logic [23:0]      dist_wdata, dist_rd_reg;
    logic             dist_rv_reg;
    logic             pred_we;
    logic [VW-1:0]    pred_waddr, pred_raddr;
    logic [7:0]       pred_wdata, pred_rd_reg;
    logic             pred_rv_reg;
    logic             pbuf_we;
    logic [VW-1:0]    pbuf_waddr, pbuf_raddr;
    logic [7:0]       pbuf_wdata, pbuf_rd_reg;

    state_t           state_reg, state_next;
    logic             ret_reg, ret_next;
    logic [7:0]       start_reg, start_next, goal_reg, goal_next;
    logic [ECW-1:0]   ecount_reg, ecount_next;
    logic             edge_ovf_reg, edge_ovf_next, queue_ovf_reg, queue_ovf_next;
    logic             found_reg, found_next;
    logic [23:0]      gdist_reg, gdist_next, goal_d_reg, goal_d_next;
    logic [PCW-1:0]   plen_reg, plen_next, ptr_reg, ptr_next, tn_reg, tn_next;
    logic [VERTEX_CODES-1:0] dv_reg, dv_next, closed_reg, closed_next;
    logic [QCW-1:0]   size_reg, size_next;
    logic [QW-1:0]    hi_reg, hi_next, chi_reg, chi_next;
    heap_entry_t      pe_reg, pe_next, top_reg, top_next, last_reg, last_next;
    heap_entry_t      ca_reg, ca_next, ch_reg, ch_next;
    logic [7:0]       u_reg, u_next, tv_reg, tv_next;
    logic [23:0]      ud_reg, ud_next, nd_reg, nd_next;
    logic [ECW-1:0]   k_reg, k_next;
    edge_t            ed_reg, ed_next;
    logic [7:0]       res_pv_reg, res_pv_next;
    logic             res_pl_reg, res_pl_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [23:0]      out_gdist_reg, out_gdist_next;
    logic [7:0]       out_pv_reg, out_pv_next;
    logic             out_pl_reg, out_pl_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             req_fire;
    logic [7:0]       req_src, req_dst, req_start, req_goal;
    logic             push_full, push_first, push_better, parent_zero;
    logic [QW-1:0]    parent_hi, parent_size;
    logic [QW+1:0]    c_idx;
    logic             c_past, c2_ok, rc2_better, cmp_better;
    logic             top_closed, stop_search, k_done, src_hit, improve;
    logic             tr_stop, emit_go, cnt_ok, rd_ok;
    logic [23:0]      dd, nd_sum;
    logic [24:0]      sum_wide;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_src   = mod_tbl[req.edge_source];
    assign req_dst   = mod_tbl[req.edge_target];
    assign req_start = mod_tbl[req.start_vertex];
    assign req_goal  = mod_tbl[req.goal_vertex];

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.goal_distance = out_gdist_reg;
    assign rsp.path_vertex   = out_pv_reg;
    assign rsp.path_last     = out_pl_reg;
    assign rsp.overflow      = out_ovf_reg;

    always_comb
    begin
        push_full   = (size_reg >= QCW'(QUEUE_DEPTH));
        push_first  = (size_reg == '0);
        parent_size = QW'((size_reg - QCW'(1)) >> 1);
        parent_hi   = (hi_reg - QW'(1)) >> 1;
        parent_zero = (parent_hi == '0);
        push_better = outranks(pe_reg, heap_rd_reg);
        c_idx       = (QW+2)'({hi_reg, 1'b1});
        c_past      = (c_idx >= (QW+2)'(size_reg));
        c2_ok       = ((QW+2)'(chi_reg) + (QW+2)'(1)) < (QW+2)'(size_reg);
        rc2_better  = outranks(heap_rd_reg, ca_reg);
        cmp_better  = outranks(ch_reg, last_reg);
        top_closed  = closed_reg[top_reg.vert[VW-1:0]];
        stop_search = ($signed({2'b00, goal_d_reg}) < top_reg.prio);
        k_done      = (k_reg >= ecount_reg);
        src_hit     = (edge_rd_reg.src == u_reg);
        sum_wide    = {1'b0, ud_reg} + {9'd0, edge_rd_reg.len};
        nd_sum      = sum_wide[24] ? DIST_INF : sum_wide[23:0];
        dd          = dist_rv_reg ? dist_rd_reg : DIST_INF;
        improve     = (dd > nd_reg);
        tr_stop     = (tv_reg == start_reg) || ((tn_reg + PCW'(1)) == PCW'(VERTEX_CODES));
        emit_go     = !out_valid_reg || rsp.ready;
        cnt_ok      = (ecount_reg < ECW'(MAX_EDGES));
        rd_ok       = (ptr_reg < plen_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_CLEAR, CMD_LOAD: state_next = ST_IDLE;
                        CMD_SEARCH:          state_next = ST_PUSH_START;
                        CMD_READ:            state_next = rd_ok ? ST_RD_W : ST_EMIT;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH_START:
            begin
                if (push_full || push_first)
                begin
                    state_next = ret_reg ? ST_EXP_K : ST_POP_START;
                end
                else
                begin
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                if (!push_better)
                begin
                    state_next = ret_reg ? ST_EXP_K : ST_POP_START;
                end
                else if (parent_zero)
                begin
                    state_next = ST_PUSH_FIN;
                end
            end
            ST_PUSH_FIN:  state_next = ret_reg ? ST_EXP_K : ST_POP_START;
            ST_POP_START: state_next = push_first ? ST_FINISH : ST_POP_TOP;
            ST_POP_TOP:   state_next = (size_reg == QCW'(1)) ? ST_CHECK : ST_POP_LAST;
            ST_POP_LAST:  state_next = ST_POP_C;
            ST_POP_C:     state_next = c_past ? ST_CHECK : ST_POP_RC1;
            ST_POP_RC1:   state_next = c2_ok ? ST_POP_RC2 : ST_POP_CMP;
            ST_POP_RC2:   state_next = ST_POP_CMP;
            ST_POP_CMP:   state_next = cmp_better ? ST_POP_C : ST_CHECK;
            ST_CHECK:
            begin
                if (top_closed)
                begin
                    state_next = ST_POP_START;
                end
                else if (stop_search)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_EXP_D;
                end
            end
            ST_EXP_D:     state_next = ST_EXP_K;
            ST_EXP_K:     state_next = k_done ? ST_POP_START : ST_EXP_E;
            ST_EXP_E:     state_next = src_hit ? ST_EXP_N : ST_EXP_K;
            ST_EXP_N:     state_next = improve ? ST_PUSH_START : ST_EXP_K;
            ST_FINISH:    state_next = (goal_d_reg != DIST_INF) ? ST_TR_W : ST_EMIT;
            ST_TR_W:      state_next = tr_stop ? ST_EMIT : ST_TR_R;
            ST_TR_R:      state_next = pred_rv_reg ? ST_TR_W : ST_EMIT;
            ST_RD_W:      state_next = ST_EMIT;
            ST_EMIT:      state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ret_next       = ret_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        ecount_next    = ecount_reg;
        edge_ovf_next  = edge_ovf_reg;
        queue_ovf_next = queue_ovf_reg;
        found_next     = found_reg;
        gdist_next     = gdist_reg;
        goal_d_next    = goal_d_reg;
        plen_next      = plen_reg;
        ptr_next       = ptr_reg;
        tn_next        = tn_reg;
        dv_next        = dv_reg;
        closed_next    = closed_reg;
        size_next      = size_reg;
        hi_next        = hi_reg;
        chi_next       = chi_reg;
        pe_next        = pe_reg;
        top_next       = top_reg;
        last_next      = last_reg;
        ca_next        = ca_reg;
        ch_next        = ch_reg;
        u_next         = u_reg;
        tv_next        = tv_reg;
        ud_next        = ud_reg;
        nd_next        = nd_reg;
        k_next         = k_reg;
        ed_next        = ed_reg;
        res_pv_next    = res_pv_reg;
        res_pl_next    = res_pl_reg;
        out_found_next = out_found_reg;
        out_gdist_next = out_gdist_reg;
        out_pv_next    = out_pv_reg;
        out_pl_next    = out_pl_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        edge_we    = 1'b0;
        edge_waddr = ecount_reg[EW-1:0];
        edge_wdata = '{src: req_src, dst: req_dst, len: req.edge_length};
        edge_raddr = k_reg[EW-1:0];
        heap_we    = 1'b0;
        heap_waddr = hi_reg;
        heap_wdata = pe_reg;
        heap_raddr = '0;
        dist_we    = 1'b0;
        dist_waddr = ed_reg.dst[VW-1:0];
        dist_wdata = nd_reg;
        dist_raddr = top_reg.vert[VW-1:0];
        pred_we    = 1'b0;
        pred_waddr = ed_reg.dst[VW-1:0];
        pred_wdata = u_reg;
        pred_raddr = tv_reg[VW-1:0];
        pbuf_we    = 1'b0;
        pbuf_waddr = tn_reg[VW-1:0];
        pbuf_wdata = tv_reg;
        pbuf_raddr = VW'(plen_reg - ptr_reg - PCW'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_CLEAR:
                        begin
                            ecount_next    = '0;
                            edge_ovf_next  = 1'b0;
                            queue_ovf_next = 1'b0;
                            found_next     = 1'b0;
                            gdist_next     = DIST_INF;
                            plen_next      = '0;
                            ptr_next       = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (cnt_ok)
                            begin
                                edge_we     = 1'b1;
                                ecount_next = ecount_reg + ECW'(1);
                            end
                            else
                            begin
                                edge_ovf_next = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            start_next     = req_start;
                            goal_next      = req_goal;
                            dv_next        = '0;
                            dv_next[req_start[VW-1:0]] = 1'b1;
                            closed_next    = '0;
                            size_next      = '0;
                            queue_ovf_next = 1'b0;
                            dist_we        = 1'b1;
                            dist_waddr     = req_start[VW-1:0];
                            dist_wdata     = '0;
                            goal_d_next    = (req_start == req_goal) ? 24'd0 : DIST_INF;
                            pe_next        = '{prio: prio_of(24'd0, req_goal, req_start),
                                               vert: req_start};
                            ret_next       = 1'b0;
                        end
                        CMD_READ:
                        begin
                            res_pv_next = '0;
                            res_pl_next = 1'b0;
                        end
                        default:
                        begin
                            res_pv_next = '0;
                        end
                    endcase
                end
            end
            ST_PUSH_START:
            begin
                if (push_full)
                begin
                    queue_ovf_next = 1'b1;
                end
                else
                begin
                    hi_next    = size_reg[QW-1:0];
                    size_next  = size_reg + QCW'(1);
                    heap_raddr = parent_size;
                    if (push_first)
                    begin
                        heap_we    = 1'b1;
                        heap_waddr = '0;
                    end
                end
            end
            ST_PUSH_CMP:
            begin
                heap_we = 1'b1;
                if (push_better)
                begin
                    heap_wdata = heap_rd_reg;
                    hi_next    = parent_hi;
                    heap_raddr = (parent_hi - QW'(1)) >> 1;
                end
            end
            ST_PUSH_FIN:
            begin
                heap_we = 1'b1;
            end
            ST_POP_START:
            begin
                heap_raddr = '0;
            end
            ST_POP_TOP:
            begin
                top_next   = heap_rd_reg;
                size_next  = size_reg - QCW'(1);
                heap_raddr = QW'(size_reg - QCW'(1));
            end
            ST_POP_LAST:
            begin
                last_next = heap_rd_reg;
                hi_next   = '0;
            end
            ST_POP_C:
            begin
                if (c_past)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = last_reg;
                end
                else
                begin
                    heap_raddr = QW'(c_idx);
                    chi_next   = QW'(c_idx);
                end
            end
            ST_POP_RC1:
            begin
                ca_next    = heap_rd_reg;
                ch_next    = heap_rd_reg;
                heap_raddr = chi_reg + QW'(1);
            end
            ST_POP_RC2:
            begin
                if (rc2_better)
                begin
                    ch_next  = heap_rd_reg;
                    chi_next = chi_reg + QW'(1);
                end
            end
            ST_POP_CMP:
            begin
                heap_we = 1'b1;
                if (cmp_better)
                begin
                    heap_wdata = ch_reg;
                    hi_next    = chi_reg;
                end
                else
                begin
                    heap_wdata = last_reg;
                end
            end
            ST_CHECK:
            begin
                if (!top_closed && !stop_search)
                begin
                    closed_next[top_reg.vert[VW-1:0]] = 1'b1;
                    u_next = top_reg.vert;
                end
            end
            ST_EXP_D:
            begin
                ud_next = dist_rd_reg;
                k_next  = '0;
            end
            ST_EXP_K:
            begin
                edge_raddr = k_reg[EW-1:0];
            end
            ST_EXP_E:
            begin
                ed_next    = edge_rd_reg;
                nd_next    = nd_sum;
                dist_raddr = edge_rd_reg.dst[VW-1:0];
                if (!src_hit)
                begin
                    k_next = k_reg + ECW'(1);
                end
            end
            ST_EXP_N:
            begin
                k_next = k_reg + ECW'(1);
                if (improve)
                begin
                    dist_we = 1'b1;
                    pred_we = 1'b1;
                    dv_next[ed_reg.dst[VW-1:0]] = 1'b1;
                    if (ed_reg.dst == goal_reg)
                    begin
                        goal_d_next = nd_reg;
                    end
                    pe_next  = '{prio: prio_of(nd_reg, goal_reg, ed_reg.dst), vert: ed_reg.dst};
                    ret_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                gdist_next  = goal_d_reg;
                found_next  = (goal_d_reg != DIST_INF);
                plen_next   = '0;
                ptr_next    = '0;
                res_pv_next = '0;
                res_pl_next = 1'b0;
                tv_next     = goal_reg;
                tn_next     = '0;
            end
            ST_TR_W:
            begin
                pbuf_we    = 1'b1;
                tn_next    = tn_reg + PCW'(1);
                pred_raddr = tv_reg[VW-1:0];
                if (tr_stop)
                begin
                    plen_next = tn_reg + PCW'(1);
                end
            end
            ST_TR_R:
            begin
                if (pred_rv_reg)
                begin
                    tv_next = pred_rd_reg;
                end
                else
                begin
                    plen_next = tn_reg;
                end
            end
            ST_RD_W:
            begin
                res_pv_next = pbuf_rd_reg;
                res_pl_next = ((ptr_reg + PCW'(1)) == plen_reg);
                ptr_next    = ptr_reg + PCW'(1);
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_gdist_next = gdist_reg;
                    out_pv_next    = res_pv_reg;
                    out_pl_next    = res_pl_reg;
                    out_ovf_next   = edge_ovf_reg || queue_ovf_reg;
                end
            end
            default:
            begin
                ret_next = ret_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rd_reg <= edge_mem[edge_raddr];
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd_reg <= heap_mem[heap_raddr];
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
        dist_rv_reg <= dv_reg[dist_raddr];
        if (pred_we)
        begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        pred_rd_reg <= pred_mem[pred_raddr];
        pred_rv_reg <= dv_reg[pred_raddr];
        if (pbuf_we)
        begin
            pbuf_mem[pbuf_waddr] <= pbuf_wdata;
        end
        pbuf_rd_reg <= pbuf_mem[pbuf_raddr];
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        goal_reg       <= goal_next;
        tn_reg         <= tn_next;
        hi_reg         <= hi_next;
        chi_reg        <= chi_next;
        pe_reg         <= pe_next;
        top_reg        <= top_next;
        last_reg       <= last_next;
        ca_reg         <= ca_next;
        ch_reg         <= ch_next;
        u_reg          <= u_next;
        tv_reg         <= tv_next;
        ud_reg         <= ud_next;
        nd_reg         <= nd_next;
        k_reg          <= k_next;
        ed_reg         <= ed_next;
        res_pv_reg     <= res_pv_next;
        res_pl_reg     <= res_pl_next;
        out_found_reg  <= out_found_next;
        out_gdist_reg  <= out_gdist_next;
        out_pv_reg     <= out_pv_next;
        out_pl_reg     <= out_pl_next;
        out_ovf_reg    <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= 1'b0;
            ecount_reg    <= '0;
            edge_ovf_reg  <= 1'b0;
            queue_ovf_reg <= 1'b0;
            found_reg     <= 1'b0;
            gdist_reg     <= DIST_INF;
            goal_d_reg    <= DIST_INF;
            plen_reg      <= '0;
            ptr_reg       <= '0;
            dv_reg        <= '0;
            closed_reg    <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            ecount_reg    <= ecount_next;
            edge_ovf_reg  <= edge_ovf_next;
            queue_ovf_reg <= queue_ovf_next;
            found_reg     <= found_next;
            gdist_reg     <= gdist_next;
            goal_d_reg    <= goal_d_next;
            plen_reg      <= plen_next;
            ptr_reg       <= ptr_next;
            dv_reg        <= dv_next;
            closed_reg    <= closed_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/asp_chk.sv
module asp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_cmd,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        found,
    input logic [23:0] goal_distance,
    input logic        path_last
);
    import asp_pkg::*;

    // A beat that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped before it was taken");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> goal_distance == DIST_INF && !path_last)
        else $error("not-found beat carries a distance or a path end");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> goal_distance != DIST_INF)
        else $error("found beat carries an infinite distance");

    // A search keeps the block busy for at least the following cycle.
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == CMD_SEARCH |=> !req_ready)
        else $error("request taken right after a search beat");

endmodule

bind astar_shortest_path asp_chk u_asp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_cmd       (req.cmd),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .found         (rsp.found),
    .goal_distance (rsp.goal_distance),
    .path_last     (rsp.path_last)
);
